// File: hw/rtl/mdm_pkg.sv
// ----------------------------------------------------------------------------
// mdm_pkg: shared types and constants of the multiply / divide / modulo unit
// Operation codes, result width and the command bundle that the controller
// sends to the datapath.
// ----------------------------------------------------------------------------
package mdm_pkg;

   localparam int RESULT_WIDTH = 32;
   localparam int OP_WIDTH     = 2;

   typedef logic [OP_WIDTH-1:0] op_type;

   localparam op_type OP_MUL = 2'd0;
   localparam op_type OP_DIV = 2'd1;
   localparam op_type OP_MOD = 2'd2;

   typedef struct packed {
      logic load;      // capture operands, clear partial result
      logic step;      // one shift-add or restore step
      logic publish;   // write the finished result to the output register
   } cmd_type;

endpackage

// File: hw/rtl/mdm_datapath.sv
// ----------------------------------------------------------------------------
// mdm_datapath: shared shift-add / restoring-divide datapath
// One pair of shift registers serves both operations: the upper half holds
// the partial product or the partial remainder, the lower half the
// multiplier or the dividend bits that turn into quotient bits.
// ----------------------------------------------------------------------------
module mdm_datapath
   import mdm_pkg::*;
#(
   parameter int OPERAND_WIDTH = 16
) (
   input  logic                     clock,
   input  cmd_type                  cmd,
   input  op_type                   req_op,
   input  logic [OPERAND_WIDTH-1:0] req_operand_a,
   input  logic [OPERAND_WIDTH-1:0] req_operand_b,
   output logic [RESULT_WIDTH-1:0]  rsp_result
);

   localparam int W = OPERAND_WIDTH;

   op_type         op_ff, op_in;
   logic [W:0]     hi_ff, hi_in;
   logic [W-1:0]   lo_ff, lo_in;
   logic [W-1:0]   addend_ff, addend_in;
   logic [RESULT_WIDTH-1:0] result_ff, result_in;

   logic [W:0]     mul_sum;
   logic [W:0]     div_shift;
   logic [W+1:0]   div_diff;
   logic [2*W-1:0] product;
   logic [RESULT_WIDTH-1:0] final_value;

   always_comb begin
      // multiply: add multiplicand when the current multiplier bit is set
      mul_sum   = {1'b0, hi_ff[W-1:0]} + (lo_ff[0] ? {1'b0, addend_ff} : '0);
      // divide: bring in the next dividend bit and try the divisor
      div_shift = {hi_ff[W-1:0], lo_ff[W-1]};
      div_diff  = {1'b0, div_shift} - {2'b00, addend_ff};
      product   = {hi_ff[W-1:0], lo_ff};

      case (op_ff)
         OP_MUL:  final_value = RESULT_WIDTH'(product);
         OP_DIV:  final_value = RESULT_WIDTH'(lo_ff);
         OP_MOD:  final_value = RESULT_WIDTH'(hi_ff[W-1:0]);
         default: final_value = '0;
      endcase
   end

   always_comb begin
      op_in     = op_ff;
      hi_in     = hi_ff;
      lo_in     = lo_ff;
      addend_in = addend_ff;
      result_in = result_ff;
      if (cmd.load) begin
         op_in = req_op;
         hi_in = '0;
         if (req_op == OP_MUL) begin
            lo_in     = req_operand_b;
            addend_in = req_operand_a;
         end else begin
            lo_in     = req_operand_a;
            addend_in = req_operand_b;
         end
      end else if (cmd.step) begin
         if (op_ff == OP_MUL) begin
            hi_in = {1'b0, mul_sum[W:1]};
            lo_in = {mul_sum[0], lo_ff[W-1:1]};
         end else if (!div_diff[W+1]) begin
            hi_in = div_diff[W:0];
            lo_in = {lo_ff[W-2:0], 1'b1};
         end else begin
            hi_in = div_shift;
            lo_in = {lo_ff[W-2:0], 1'b0};
         end
      end
      if (cmd.publish) begin
         result_in = final_value;
      end
   end

   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      hi_ff     <= hi_in;
      lo_ff     <= lo_in;
      addend_ff <= addend_in;
      result_ff <= result_in;
   end

   assign rsp_result = result_ff;

endmodule

// File: hw/rtl/mdm_ctrl.sv
// ----------------------------------------------------------------------------
// mdm_ctrl: sequencing controller
// Takes a beat when idle, runs one datapath step per operand bit, then
// moves the result into the output register as soon as that is free.
// ----------------------------------------------------------------------------
module mdm_ctrl
   import mdm_pkg::*;
#(
   parameter int OPERAND_WIDTH = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output cmd_type cmd
);

   localparam int CNT_W = $clog2(OPERAND_WIDTH);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_STEP = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   logic [1:0]       state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             valid_ff, valid_in;
   logic             out_free;

   assign out_free  = !valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = valid_ff;

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      cmd.load    = 1'b0;
      cmd.step    = 1'b0;
      cmd.publish = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               count_in = CNT_W'(OPERAND_WIDTH - 1);
               state_in = ST_STEP;
            end
         end
         ST_STEP: begin
            cmd.step = 1'b1;
            count_in = count_ff - CNT_W'(1);
            if (count_ff == '0) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               cmd.publish = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      // output register: filled on publish, emptied when the beat is taken
      if (cmd.publish) begin
         valid_in = 1'b1;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
      count_ff <= count_in;
   end

endmodule

// File: hw/rtl/mul_div_mod_unit.sv
// ----------------------------------------------------------------------------
// mul_div_mod_unit: unsigned multiply / divide / modulo unit
//
//   channel  direction  ports                                   beat
//   req      in         req_valid req_stall req_op               one operation
//                       req_operand_a req_operand_b
//   rsp      out        rsp_valid rsp_stall rsp_result           one result
//
// A beat that is taken runs one step of the shared shift-add / restoring-divide
// datapath per operand bit; its result is then published into the output
// register as soon as that register is free. The controller returns to idle
// after the publish and can take the next beat from there.
// One operation is in flight at a time; req_stall is high while it runs.
// The finished result sits in an output register, so a new beat is taken
// while the previous result is still stalled on rsp.
// Synchronous reset clears the controller and the output valid.
// ----------------------------------------------------------------------------
module mul_div_mod_unit
   import mdm_pkg::*;
#(
   parameter int OPERAND_WIDTH = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  op_type                   req_op,
   input  logic [OPERAND_WIDTH-1:0] req_operand_a,
   input  logic [OPERAND_WIDTH-1:0] req_operand_b,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [RESULT_WIDTH-1:0]  rsp_result
);

   cmd_type cmd;

   mdm_ctrl #(
      .OPERAND_WIDTH (OPERAND_WIDTH)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   mdm_datapath #(
      .OPERAND_WIDTH (OPERAND_WIDTH)
   ) u_datapath (
      .clock         (clock),
      .cmd           (cmd),
      .req_op        (req_op),
      .req_operand_a (req_operand_a),
      .req_operand_b (req_operand_b),
      .rsp_result    (rsp_result)
   );

endmodule

// File: tb/sv/mul_div_mod_unit_tb.sv
// ----------------------------------------------------------------------------
// mul_div_mod_unit_tb: self-checking bench for the multiply / divide / modulo unit
// Directed corner operations, then random operations, are fed through a
// bursty sender. Each accepted beat is predicted by a local multiply /
// restoring-divide model, and every result is checked in order against the
// queue of expected values while the result side stalls on its own pattern.
// ----------------------------------------------------------------------------
module mul_div_mod_unit_tb
   import mdm_pkg::*;
();

   localparam int     OPND_W       = 16;
   localparam int     RANDOM_OPS   = 1650;
   localparam int     IDLE_LIMIT   = 4000;
   localparam int     HOLD_CYCLES  = 300;
   localparam int     HOLD_AFTER   = 200;
   localparam int     DRAIN_CYCLES = 40;
   localparam op_type OP_UNUSED    = 2'd3;

   typedef struct packed {
      op_type            op;
      logic [OPND_W-1:0] a;
      logic [OPND_W-1:0] b;
   } op_beat_type;

   typedef struct packed {
      op_type                  op;
      logic [OPND_W-1:0]       a;
      logic [OPND_W-1:0]       b;
      logic [RESULT_WIDTH-1:0] result;
   } expected_result_type;

   typedef enum logic [1:0] {STALL_NONE, STALL_HALF, STALL_RARE, STALL_HEAVY} stall_mode_type;

   logic                    clock         = 1'b0;
   logic                    reset         = 1'b1;
   logic                    req_valid     = 1'b0;
   logic                    req_stall;
   op_type                  req_op        = OP_MUL;
   logic [OPND_W-1:0]       req_operand_a = '0;
   logic [OPND_W-1:0]       req_operand_b = '0;
   logic                    rsp_valid;
   logic                    rsp_stall     = 1'b0;
   logic [RESULT_WIDTH-1:0] rsp_result;

   op_beat_type         pending_ops[$];
   expected_result_type expected_results[$];

   int mismatch_count  = 0;
   int results_checked = 0;
   int op_seen[4]      = '{0, 0, 0, 0};
   int idle_cycles     = 0;
   int hold_left       = 0;
   bit hold_done       = 1'b0;
   logic hold_active;

   assign hold_active = (hold_left != 0);

   always #4 clock = ~clock;

   mul_div_mod_unit #(
      .OPERAND_WIDTH(OPND_W)
   ) u_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_op        (req_op),
      .req_operand_a (req_operand_a),
      .req_operand_b (req_operand_b),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_result    (rsp_result)
   );

   // product, or quotient / remainder by trial subtraction from bit 15 down
   function automatic logic [RESULT_WIDTH-1:0] predict_result(op_type op,
         logic [OPND_W-1:0] a, logic [OPND_W-1:0] b);
      logic [RESULT_WIDTH-1:0] rem;
      logic [RESULT_WIDTH-1:0] trial;
      logic [OPND_W-1:0]       quo;
      int                      i;
      rem = {{(RESULT_WIDTH-OPND_W){1'b0}}, a};
      quo = '0;
      for (i = OPND_W - 1; i >= 0; i--) begin
         trial = {{(RESULT_WIDTH-OPND_W){1'b0}}, b} << i;
         if (trial <= rem) begin
            rem    = rem - trial;
            quo[i] = 1'b1;
         end
      end
      case (op)
         OP_MUL:  return {{(RESULT_WIDTH-OPND_W){1'b0}}, a} *
                         {{(RESULT_WIDTH-OPND_W){1'b0}}, b};
         OP_DIV:  return {{(RESULT_WIDTH-OPND_W){1'b0}}, quo};
         OP_MOD:  return rem;
         default: return '0;
      endcase
   endfunction

   function automatic logic [OPND_W-1:0] random_operand();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         2:       return OPND_W'($urandom_range(1, 15));
         3:       return OPND_W'(1) << $urandom_range(0, OPND_W - 1);
         4:       return OPND_W'('1) - OPND_W'($urandom_range(0, 7));
         5:       return OPND_W'($urandom_range(0, 255));
         default: return OPND_W'($urandom);
      endcase
   endfunction

   function automatic op_type random_op();
      case ($urandom_range(0, 19))
         0:       return OP_UNUSED;
         1, 2, 3, 4, 5, 6:    return OP_MUL;
         7, 8, 9, 10, 11, 12: return OP_DIV;
         default: return OP_MOD;
      endcase
   endfunction

   task automatic add_op(op_type op, logic [OPND_W-1:0] a, logic [OPND_W-1:0] b);
      op_beat_type beat;
      beat.op = op;
      beat.a  = a;
      beat.b  = b;
      pending_ops.push_back(beat);
   endtask

   task automatic report_mismatch(string msg);
      $display("mismatch @%0t: %s", $time, msg);
      mismatch_count++;
   endtask

   // sender: bursts of beats with random gaps, payload held while stalled
   always @(posedge clock) begin : op_sender
      op_beat_type         nxt;
      expected_result_type exp_r;
      static int           burst_left = 1;
      static int           gap_left   = 0;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            exp_r.op     = req_op;
            exp_r.a      = req_operand_a;
            exp_r.b      = req_operand_b;
            exp_r.result = predict_result(req_op, req_operand_a, req_operand_b);
            expected_results.push_back(exp_r);
         end
         if (!req_valid || !req_stall) begin
            if (gap_left != 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_ops.size() != 0) begin
               nxt = pending_ops.pop_front();
               req_valid     <= 1'b1;
               req_op        <= nxt.op;
               req_operand_a <= nxt.a;
               req_operand_b <= nxt.b;
               if (burst_left <= 1) begin
                  burst_left = $urandom_range(1, 12);
                  gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
               end else begin
                  burst_left--;
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver stall pattern, switched to a random mode at the end of each phase
   always @(posedge clock) begin : result_stall
      logic                  pat;
      static int             phase_left = 0;
      static stall_mode_type stall_mode = STALL_NONE;
      if (phase_left == 0) begin
         stall_mode = stall_mode_type'($urandom_range(0, 3));
         phase_left = $urandom_range(16, 96);
      end else begin
         phase_left--;
      end
      case (stall_mode)
         STALL_NONE: pat = 1'b0;
         STALL_HALF: pat = 1'($urandom_range(0, 1));
         STALL_RARE: pat = ($urandom_range(0, 7) == 0);
         default:    pat = ($urandom_range(0, 3) != 0);
      endcase
      rsp_stall <= hold_active || pat;
   end

   // one long hold-off on the result side so the unit backs up into req_stall
   always @(posedge clock) begin
      if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end else if (!hold_done && results_checked >= HOLD_AFTER) begin
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end
   end

   always @(posedge clock) begin : result_check
      expected_result_type exp_r;
      if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
         if (expected_results.size() == 0) begin
            report_mismatch($sformatf("result %h with no operation outstanding", rsp_result));
         end else begin
            exp_r = expected_results.pop_front();
            results_checked++;
            op_seen[exp_r.op]++;
            if (rsp_result !== exp_r.result)
               report_mismatch($sformatf("op %0d a %h b %h: result %h, want %h",
                  exp_r.op, exp_r.a, exp_r.b, rsp_result, exp_r.result));
         end
      end
   end

   always @(posedge clock) begin : watchdog
      if (reset || (req_valid && !req_stall) || (rsp_valid === 1'b1 && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("watchdog: no beat for %0d cycles, %0d results still due",
            idle_cycles, expected_results.size());
         $display("RESULT: ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int i;
      // corners: extremes, divide by zero, dividend below divisor, unused selector
      add_op(OP_MUL, 16'h0000, 16'h0000);
      add_op(OP_MUL, 16'hFFFF, 16'hFFFF);
      add_op(OP_MUL, 16'hFFFF, 16'h0001);
      add_op(OP_MUL, 16'h1234, 16'h0000);
      add_op(OP_MUL, 16'h8000, 16'h8000);
      add_op(OP_DIV, 16'hFFFF, 16'h0001);
      add_op(OP_DIV, 16'hFFFF, 16'hFFFF);
      add_op(OP_DIV, 16'h0000, 16'h0005);
      add_op(OP_DIV, 16'h1234, 16'h0000);
      add_op(OP_DIV, 16'h0000, 16'h0000);
      add_op(OP_DIV, 16'h0005, 16'h0007);
      add_op(OP_DIV, 16'hFFFF, 16'h0002);
      add_op(OP_DIV, 16'hAAAA, 16'h5555);
      add_op(OP_MOD, 16'hFFFF, 16'h0000);
      add_op(OP_MOD, 16'h0000, 16'h0000);
      add_op(OP_MOD, 16'hFFFF, 16'hFFFF);
      add_op(OP_MOD, 16'h0005, 16'h0007);
      add_op(OP_MOD, 16'hFFFF, 16'h8000);
      add_op(OP_MOD, 16'h8000, 16'h0003);
      add_op(OP_MOD, 16'h5555, 16'hAAAA);
      add_op(OP_UNUSED, 16'hFFFF, 16'hFFFF);
      add_op(OP_UNUSED, 16'h0000, 16'h0000);
      for (i = 0; i < RANDOM_OPS; i++)
         add_op(random_op(), random_operand(), random_operand());

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      while (pending_ops.size() != 0 || req_valid || expected_results.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("checked %0d results: %0d multiply, %0d divide, %0d modulo, %0d unused op",
         results_checked, op_seen[OP_MUL], op_seen[OP_DIV], op_seen[OP_MOD],
         op_seen[OP_UNUSED]);
      $display("bursty sender, mixed result stalls, one %0d-cycle result hold-off; %0d mismatches",
         HOLD_CYCLES, mismatch_count);
      if (mismatch_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
